/* sv/bie_pkg.sv */
// Package for the Bessel I0 evaluator: widths, constants, request structs
// and the Chebyshev coefficient tables (decimal, units of 1e-18, and Q56).
// No dependencies.
`timescale 1ns / 1ps
package bie_pkg;

    localparam int LOW_TERMS     = 30;
    localparam int HIGH_TERMS    = 25;
    localparam int ARG_FRAC_BITS = 16;
    localparam int WORK_FRAC     = 24;
    localparam int EXP_TERMS     = 20;
    localparam int EXP_SQUARINGS = 6;

    localparam int ARG_W = 22;
    localparam int OUT_W = 64;
    localparam int XQ_W  = 30;
    localparam int EXP_W = 12;
    localparam int IDX_W = 5;

    localparam int LOW_TAB_N  = 30;
    localparam int HIGH_TAB_N = 25;

    // shift of |x| (Q.24) into the exp reduction argument, Q62 of x/64
    localparam int EXP_ARG_SHIFT = 62 - EXP_SQUARINGS - WORK_FRAC;
    // shift of |x| into y for the low range (x/2 in Q56)
    localparam int LOW_Y_SHIFT   = 55 - WORK_FRAC;

    localparam logic [63:0] COEF_UNIT = 64'd1000000000000000000;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
        logic [6:0]  bits;
        logic        rnd;
    } div_req_t;

    // one Q56 coefficient per table index
    typedef logic [31:0][63:0] coef_tab_t;

    // Series coefficients, low range (x <= 8) and high range (x > 8)
    function automatic logic signed [63:0] coef_raw(input logic high,
                                                    input logic [IDX_W-1:0] idx);
        logic signed [63:0] c;
        c = '0;
        if (!high) begin
            case (idx)
                5'd0:  c = -64'sd4;
                5'd1:  c = 64'sd33;
                5'd2:  c = -64'sd243;
                5'd3:  c = 64'sd1715;
                5'd4:  c = -64'sd11685;
                5'd5:  c = 64'sd76762;
                5'd6:  c = -64'sd485645;
                5'd7:  c = 64'sd2955053;
                5'd8:  c = -64'sd17268263;
                5'd9:  c = 64'sd96758090;
                5'd10: c = -64'sd518979560;
                5'd11: c = 64'sd2659823725;
                5'd12: c = -64'sd13000250100;
                5'd13: c = 64'sd60469950225;
                5'd14: c = -64'sd267079385394;
                5'd15: c = 64'sd1117387539120;
                5'd16: c = -64'sd4416738358459;
                5'd17: c = 64'sd16448448070729;
                5'd18: c = -64'sd57541950100821;
                5'd19: c = 64'sd188502885095842;
                5'd20: c = -64'sd576375574538582;
                5'd21: c = 64'sd1639475616941336;
                5'd22: c = -64'sd4324309995050576;
                5'd23: c = 64'sd10546460394594998;
                5'd24: c = -64'sd23737414805899469;
                5'd25: c = 64'sd49305284239670708;
                5'd26: c = -64'sd94901097048047644;
                5'd27: c = 64'sd171620901522208775;
                5'd28: c = -64'sd304682672343198399;
                5'd29: c = 64'sd676795274409476085;
                default: c = '0;
            endcase
        end else begin
            case (idx)
                5'd0:  c = -64'sd7;
                5'd1:  c = -64'sd5;
                5'd2:  c = 64'sd45;
                5'd3:  c = 64'sd35;
                5'd4:  c = -64'sd283;
                5'd5:  c = -64'sd343;
                5'd6:  c = 64'sd1773;
                5'd7:  c = 64'sd3812;
                5'd8:  c = -64'sd9555;
                5'd9:  c = -64'sd41506;
                5'd10: c = 64'sd15401;
                5'd11: c = 64'sd385278;
                5'd12: c = 64'sd718012;
                5'd13: c = -64'sd1794179;
                5'd14: c = -64'sd13215812;
                5'd15: c = -64'sd31499165;
                5'd16: c = 64'sd11889147;
                5'd17: c = 64'sd494060239;
                5'd18: c = 64'sd3396232026;
                5'd19: c = 64'sd22666689905;
                5'd20: c = 64'sd204891858947;
                5'd21: c = 64'sd2891370520835;
                5'd22: c = 64'sd68897583469168;
                5'd23: c = 64'sd3369116478255694;
                5'd24: c = 64'sd804490411014108832;
                default: c = '0;
            endcase
        end
        return c;
    endfunction

    // round(|c| * 2^56 / 1e18) by long division, sign restored
    function automatic logic [63:0] coef_q56_of(input logic signed [63:0] c);
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        mag = c[63] ? 64'(-c) : 64'(c);
        q   = '0;
        r   = '0;
        for (int i = 0; i < 120; i++) begin
            r = {r[62:0], (i < 64) ? mag[6'(63 - i)] : 1'b0};
            q = {q[62:0], 1'b0};
            if (r >= COEF_UNIT) begin
                r    = r - COEF_UNIT;
                q[0] = 1'b1;
            end
        end
        if ((r << 1) >= COEF_UNIT) q = q + 64'd1;
        return c[63] ? 64'(-q) : q;
    endfunction

    function automatic coef_tab_t build_coef_tab(input logic high);
        coef_tab_t t;
        t = '0;
        for (int i = 0; i < 32; i++) begin
            t[i] = coef_q56_of(coef_raw(high, IDX_W'(i)));
        end
        return t;
    endfunction

    localparam coef_tab_t LOW_COEF_Q56  = build_coef_tab(1'b0);
    localparam coef_tab_t HIGH_COEF_Q56 = build_coef_tab(1'b1);

endpackage

/* sv/bie_mul.sv */
// 64x64 unsigned multiplier built from one 32x32 multiplier used in turn for each partial product.
// Depends on bie_pkg (mul_req_t).
`timescale 1ns / 1ps
module bie_mul
    import bie_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  mul_req_t     req,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg, b_reg;
    logic [2:0]   step_reg;
    logic         busy_reg;
    logic [63:0]  pp_reg;
    logic [1:0]   pp_sh_reg;
    logic         pp_vld_reg, pp_last_reg;
    logic [127:0] acc_reg;
    logic         done_reg;

    logic [31:0]  opa, opb;
    logic [1:0]   sh;

    // pick operand halves for the current partial product
    always_comb begin
        case (step_reg)
            3'd0:    begin opa = a_reg[31:0];  opb = b_reg[31:0];  sh = 2'd0; end
            3'd1:    begin opa = a_reg[31:0];  opb = b_reg[63:32]; sh = 2'd1; end
            3'd2:    begin opa = a_reg[63:32]; opb = b_reg[31:0];  sh = 2'd1; end
            default: begin opa = a_reg[63:32]; opb = b_reg[63:32]; sh = 2'd2; end
        endcase
    end

    // partial product stage, then accumulate stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            pp_vld_reg  <= 1'b0;
            pp_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end else begin
            if (req.start) begin
                a_reg    <= req.a;
                b_reg    <= req.b;
                step_reg <= '0;
                busy_reg <= 1'b1;
                acc_reg  <= '0;
            end else if (pp_vld_reg) begin
                acc_reg <= acc_reg + ({64'd0, pp_reg} << (32 * pp_sh_reg));
            end
            if (busy_reg && !req.start) begin
                pp_reg      <= 64'(opa * opb);
                pp_sh_reg   <= sh;
                pp_vld_reg  <= 1'b1;
                pp_last_reg <= (step_reg == 3'd3);
                step_reg    <= step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    busy_reg <= 1'b0;
                end
            end else begin
                pp_vld_reg  <= 1'b0;
                pp_last_reg <= 1'b0;
            end
            done_reg <= pp_vld_reg && pp_last_reg;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* sv/bie_div.sv */
// Restoring divider, one quotient bit per cycle: floor or rounded
// num * 2^bits / den. Depends on bie_pkg (div_req_t).
`timescale 1ns / 1ps
module bie_div
    import bie_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  div_req_t    req,
    output logic        done,
    output logic [63:0] quot
);

    logic [63:0] num_reg, den_reg, q_reg;
    logic [64:0] r_reg;
    logic [7:0]  cnt_reg, total_reg;
    logic        rnd_reg, busy_reg, fin_reg, done_reg;

    logic [64:0] r2;
    logic        ge;

    assign r2 = {r_reg[63:0], num_reg[63]};
    assign ge = (r2 >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (req.start) begin
                num_reg   <= req.num;
                den_reg   <= req.den;
                rnd_reg   <= req.rnd;
                total_reg <= 8'd64 + 8'(req.bits);
                r_reg     <= '0;
                q_reg     <= '0;
                cnt_reg   <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                // one long-division step, numerator bits then zeros
                num_reg <= {num_reg[62:0], 1'b0};
                if (ge) begin
                    r_reg <= r2 - {1'b0, den_reg};
                    q_reg <= {q_reg[62:0], 1'b1};
                end else begin
                    r_reg <= r2;
                    q_reg <= {q_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 8'd1;
                if (cnt_reg == total_reg - 8'd1) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                // round to nearest on twice the remainder
                if (rnd_reg && ({r_reg, 1'b0} >= {2'b00, den_reg})) begin
                    q_reg <= q_reg + 64'd1;
                end
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* sv/bessel_i0_evaluator.sv */
// Bessel I0 evaluator: one argument per transfer, one result per transfer.
// The time from input transfer to result valid is longer for x > 8 and is set mostly by
// exp: 20 Taylor terms, each a product on the shared multiplier plus a bit-serial divide
// by the term index. One argument in flight: no new argument is taken until the result
// has been accepted.
// Reset (aresetn low, synchronous) returns the sequencer to idle, no result pending.
`timescale 1ns / 1ps
module bessel_i0_evaluator
    import bie_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [ARG_W-1:0] s_x_arg,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [OUT_W-1:0]        m_i0_value
);

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_YDIV, S_COEF, S_CWAIT, S_DFIN, S_NORM,
        S_EXPMUL, S_EXPMW, S_EXPDW, S_SQ, S_SQW, S_VMUL, S_VMW,
        S_SQRT, S_INVDIV, S_INVMUL, S_INVMW, S_CONV, S_OUT
    } state_t;

    state_t                state_reg;
    logic [XQ_W-1:0]       xq_reg;
    logic                  high_reg;
    logic signed [63:0]    y_reg, b0_reg, b1_reg, b2_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  pneg_reg;
    logic [63:0]           dm_reg, nm_reg, fm_reg, vm_reg;
    logic signed [EXP_W-1:0] de_reg, ne_reg, fe_reg, ve_reg;
    logic                  nphase_reg;
    logic [63:0]           term_reg, sum_reg;
    logic [4:0]            k_reg;
    logic [2:0]            sqc_reg;
    logic [63:0]           sqn_reg, sqres_reg, sqbit_reg;
    logic [5:0]            sqcnt_reg;
    logic [OUT_W-1:0]      out_reg;
    logic                  mvalid_reg;
    mul_req_t              mreq_reg;
    div_req_t              dreq_reg;

    logic                  mul_done, div_done;
    logic [127:0]          mul_prod;
    logic [63:0]           div_q;

    bie_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    bie_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    // argument magnitude in Q.24, saturated at 32
    logic [ARG_W-1:0] mag;
    logic [39:0]      xq_wide;
    logic [XQ_W-1:0]  xq_in;
    assign mag     = s_x_arg[ARG_W-1] ? (~s_x_arg + 1'b1) : s_x_arg;
    assign xq_wide = 40'(mag) << (WORK_FRAC - ARG_FRAC_BITS);
    assign xq_in   = (xq_wide > (40'd32 << WORK_FRAC)) ? XQ_W'(32'd32 << WORK_FRAC)
                                                       : xq_wide[XQ_W-1:0];

    // rounded Q56 product of magnitudes with sign and clip
    logic [127:0]       prod_rnd;
    logic [63:0]        smag;
    logic signed [63:0] sval;
    always_comb begin
        prod_rnd = mul_prod + (128'd1 << 55);
        smag     = prod_rnd[119:56];
        if ((|prod_rnd[127:120]) || smag[63]) begin
            smag = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        sval = pneg_reg ? -$signed(smag) : $signed(smag);
    end

    // normalized float product from the multiplier
    logic [63:0]           fp_m;
    logic signed [EXP_W-1:0] fp_add;
    assign fp_m   = mul_prod[127] ? mul_prod[127:64] : mul_prod[126:63];
    assign fp_add = mul_prod[127] ? EXP_W'(64) : EXP_W'(63);

    // current coefficient (Q56 table) and series bounds
    logic signed [63:0] cq;
    logic [IDX_W-1:0]   first_idx, last_idx;
    assign cq        = high_reg ? $signed(HIGH_COEF_Q56[idx_reg])
                                : $signed(LOW_COEF_Q56[idx_reg]);
    assign first_idx = high_reg ? IDX_W'(HIGH_TAB_N - HIGH_TERMS)
                                : IDX_W'(LOW_TAB_N - LOW_TERMS);
    assign last_idx  = high_reg ? IDX_W'(HIGH_TAB_N) : IDX_W'(LOW_TAB_N);

    // magnitudes for the y*b1 product (b1 takes the current b0)
    logic [63:0] ymag, bmag;
    assign ymag = y_reg[63] ? 64'(-y_reg) : 64'(y_reg);
    assign bmag = b0_reg[63] ? 64'(-b0_reg) : 64'(b0_reg);

    // integer square root step
    logic [63:0] sq_try;
    assign sq_try = sqres_reg + sqbit_reg;

    // final shift into Q44.20
    logic signed [EXP_W-1:0] sh;
    logic [EXP_W-1:0]        kshift;
    logic [63:0]             conv;
    always_comb begin
        sh     = ve_reg + EXP_W'(20);
        kshift = EXP_W'(-sh);
        if (sh > 0) begin
            conv = '1;
        end else if (sh == 0) begin
            conv = vm_reg;
        end else if (kshift > EXP_W'(64)) begin
            conv = '0;
        end else if (kshift == EXP_W'(64)) begin
            conv = {63'd0, vm_reg[63]};
        end else begin
            conv = (vm_reg >> kshift[5:0]) + {63'd0, vm_reg[kshift[5:0] - 6'd1]};
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            mvalid_reg     <= 1'b0;
            mreq_reg.start <= 1'b0;
            dreq_reg.start <= 1'b0;
        end else begin
            mreq_reg.start <= 1'b0;
            dreq_reg.start <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        xq_reg    <= xq_in;
                        high_reg  <= (xq_in > XQ_W'(32'd8 << WORK_FRAC));
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    b0_reg  <= '0;
                    b1_reg  <= '0;
                    b2_reg  <= '0;
                    idx_reg <= first_idx;
                    if (high_reg) begin
                        dreq_reg  <= '{1'b1, 64'd32 << WORK_FRAC, 64'(xq_reg), 7'd56, 1'b1};
                        state_reg <= S_YDIV;
                    end else begin
                        y_reg     <= $signed(64'(xq_reg) << LOW_Y_SHIFT) - $signed(64'd2 << 56);
                        state_reg <= S_COEF;
                    end
                end
                S_YDIV: begin
                    if (div_done) begin
                        y_reg     <= $signed(div_q) - $signed(64'd2 << 56);
                        state_reg <= S_COEF;
                    end
                end
                // Clenshaw step: shift b's, start product
                S_COEF: begin
                    b2_reg    <= b1_reg;
                    b1_reg    <= b0_reg;
                    pneg_reg  <= y_reg[63] ^ b0_reg[63];
                    mreq_reg  <= '{1'b1, ymag, bmag};
                    state_reg <= S_CWAIT;
                end
                // add the table coefficient once the product is in
                S_CWAIT: begin
                    if (mul_done) begin
                        b0_reg  <= sval - b2_reg + cq;
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == last_idx) begin
                            state_reg <= S_DFIN;
                        end else begin
                            state_reg <= S_COEF;
                        end
                    end
                end
                S_DFIN: begin
                    if ((b0_reg - b2_reg) <= 0) begin
                        out_reg    <= '0;
                        mvalid_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end else begin
                        nm_reg     <= 64'(b0_reg - b2_reg);
                        ne_reg     <= -EXP_W'(57);
                        nphase_reg <= 1'b0;
                        sum_reg    <= 64'd1 << 62;
                        term_reg   <= 64'd1 << 62;
                        k_reg      <= 5'd1;
                        state_reg  <= S_NORM;
                    end
                end
                // normalize one bit per cycle
                S_NORM: begin
                    if (!nm_reg[63]) begin
                        nm_reg <= {nm_reg[62:0], 1'b0};
                        ne_reg <= ne_reg - EXP_W'(1);
                    end else if (!nphase_reg) begin
                        dm_reg    <= nm_reg;
                        de_reg    <= ne_reg;
                        state_reg <= S_EXPMUL;
                    end else begin
                        mreq_reg  <= '{1'b1, vm_reg, nm_reg};
                        ve_reg    <= ve_reg + ne_reg;
                        state_reg <= S_INVMW;
                    end
                end
                S_EXPMUL: begin
                    mreq_reg  <= '{1'b1, term_reg, 64'(xq_reg) << EXP_ARG_SHIFT};
                    state_reg <= S_EXPMW;
                end
                S_EXPMW: begin
                    if (mul_done) begin
                        dreq_reg  <= '{1'b1, mul_prod[125:62], 64'(k_reg), 7'd0, 1'b0};
                        state_reg <= S_EXPDW;
                    end
                end
                S_EXPDW: begin
                    if (div_done) begin
                        term_reg <= div_q;
                        sum_reg  <= sum_reg + div_q;
                        k_reg    <= k_reg + 5'd1;
                        if (k_reg == 5'(EXP_TERMS)) begin
                            fm_reg    <= (sum_reg + div_q) << 1;
                            fe_reg    <= -EXP_W'(63);
                            sqc_reg   <= '0;
                            state_reg <= S_SQ;
                        end else begin
                            state_reg <= S_EXPMUL;
                        end
                    end
                end
                S_SQ: begin
                    mreq_reg  <= '{1'b1, fm_reg, fm_reg};
                    state_reg <= S_SQW;
                end
                S_SQW: begin
                    if (mul_done) begin
                        fm_reg  <= fp_m;
                        fe_reg  <= fe_reg + fe_reg + fp_add;
                        sqc_reg <= sqc_reg + 3'd1;
                        if (sqc_reg == 3'(EXP_SQUARINGS - 1)) begin
                            state_reg <= S_VMUL;
                        end else begin
                            state_reg <= S_SQ;
                        end
                    end
                end
                S_VMUL: begin
                    mreq_reg  <= '{1'b1, dm_reg, fm_reg};
                    state_reg <= S_VMW;
                end
                S_VMW: begin
                    if (mul_done) begin
                        vm_reg    <= fp_m;
                        ve_reg    <= de_reg + fe_reg + fp_add;
                        sqn_reg   <= 64'(xq_reg) << WORK_FRAC;
                        sqres_reg <= '0;
                        sqbit_reg <= 64'd1 << 62;
                        sqcnt_reg <= '0;
                        state_reg <= high_reg ? S_SQRT : S_CONV;
                    end
                end
                // integer square root, two bits of radicand per cycle
                S_SQRT: begin
                    if (sqn_reg >= sq_try) begin
                        sqn_reg   <= sqn_reg - sq_try;
                        sqres_reg <= (sqres_reg >> 1) + sqbit_reg;
                    end else begin
                        sqres_reg <= sqres_reg >> 1;
                    end
                    sqbit_reg <= sqbit_reg >> 2;
                    sqcnt_reg <= sqcnt_reg + 6'd1;
                    if (sqcnt_reg == 6'd31) begin
                        state_reg <= S_INVDIV;
                    end
                end
                S_INVDIV: begin
                    dreq_reg  <= '{1'b1, 64'd1, sqres_reg, 7'(64 + WORK_FRAC), 1'b1};
                    state_reg <= S_INVMUL;
                end
                S_INVMUL: begin
                    if (div_done) begin
                        nm_reg     <= div_q;
                        ne_reg     <= -EXP_W'(64);
                        nphase_reg <= 1'b1;
                        state_reg  <= S_NORM;
                    end
                end
                S_INVMW: begin
                    if (mul_done) begin
                        vm_reg    <= fp_m;
                        ve_reg    <= ve_reg + fp_add;
                        state_reg <= S_CONV;
                    end
                end
                S_CONV: begin
                    out_reg    <= conv;
                    mvalid_reg <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        mvalid_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready    = (state_reg == S_IDLE);
    assign m_valid    = mvalid_reg;
    assign m_i0_value = out_reg;

`ifndef SYNTH
    // no new argument while a result is pending
    a_ready_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input ready while result pending");

    // a taken argument makes the block busy
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("still ready after input transfer");

    // series index stays inside its table
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_COEF) |-> (idx_reg < last_idx))
        else $error("coefficient index out of range");
`endif

endmodule
